### hw/rtl/sha512_pkg.sv
// Package: shared types, constants and round functions of the SHA-512 engine.
`timescale 1ns / 1ps
`default_nettype none
package sha512_pkg;

  localparam int unsigned ROUNDS      = 80;
  localparam int unsigned BLOCK_WORDS = 16;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);

  typedef enum logic [1:0] {
    FS_ACCEPT,
    FS_MARK,
    FS_PAD,
    FS_LEN
  } front_state_t;

  typedef enum logic [1:0] {
    BS_LOAD,
    BS_ROUND,
    BS_UPDATE,
    BS_EMIT
  } back_state_t;

  // One padded message word headed for the block buffer.
  typedef struct packed {
    logic [63:0] word;
    logic        last;
  } push_t;

  // Handshake between two modules inside the engine.
  typedef struct packed {
    logic  valid;
    push_t data;
  } push_req_t;

  function automatic logic [63:0] init_value(input logic [2:0] idx);
    logic [63:0] r;
    case (idx)
      3'd0:    r = 64'h6a09e667f3bcc908;
      3'd1:    r = 64'hbb67ae8584caa73b;
      3'd2:    r = 64'h3c6ef372fe94f82b;
      3'd3:    r = 64'ha54ff53a5f1d36f1;
      3'd4:    r = 64'h510e527fade682d1;
      3'd5:    r = 64'h9b05688c2b3e6c1f;
      3'd6:    r = 64'h1f83d9abfb41bd6b;
      3'd7:    r = 64'h5be0cd19137e2179;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] round_const(input logic [6:0] t);
    logic [63:0] r;
    case (t)
      7'd0:  r = 64'h428a2f98d728ae22; 7'd1:  r = 64'h7137449123ef65cd;
      7'd2:  r = 64'hb5c0fbcfec4d3b2f; 7'd3:  r = 64'he9b5dba58189dbbc;
      7'd4:  r = 64'h3956c25bf348b538; 7'd5:  r = 64'h59f111f1b605d019;
      7'd6:  r = 64'h923f82a4af194f9b; 7'd7:  r = 64'hab1c5ed5da6d8118;
      7'd8:  r = 64'hd807aa98a3030242; 7'd9:  r = 64'h12835b0145706fbe;
      7'd10: r = 64'h243185be4ee4b28c; 7'd11: r = 64'h550c7dc3d5ffb4e2;
      7'd12: r = 64'h72be5d74f27b896f; 7'd13: r = 64'h80deb1fe3b1696b1;
      7'd14: r = 64'h9bdc06a725c71235; 7'd15: r = 64'hc19bf174cf692694;
      7'd16: r = 64'he49b69c19ef14ad2; 7'd17: r = 64'hefbe4786384f25e3;
      7'd18: r = 64'h0fc19dc68b8cd5b5; 7'd19: r = 64'h240ca1cc77ac9c65;
      7'd20: r = 64'h2de92c6f592b0275; 7'd21: r = 64'h4a7484aa6ea6e483;
      7'd22: r = 64'h5cb0a9dcbd41fbd4; 7'd23: r = 64'h76f988da831153b5;
      7'd24: r = 64'h983e5152ee66dfab; 7'd25: r = 64'ha831c66d2db43210;
      7'd26: r = 64'hb00327c898fb213f; 7'd27: r = 64'hbf597fc7beef0ee4;
      7'd28: r = 64'hc6e00bf33da88fc2; 7'd29: r = 64'hd5a79147930aa725;
      7'd30: r = 64'h06ca6351e003826f; 7'd31: r = 64'h142929670a0e6e70;
      7'd32: r = 64'h27b70a8546d22ffc; 7'd33: r = 64'h2e1b21385c26c926;
      7'd34: r = 64'h4d2c6dfc5ac42aed; 7'd35: r = 64'h53380d139d95b3df;
      7'd36: r = 64'h650a73548baf63de; 7'd37: r = 64'h766a0abb3c77b2a8;
      7'd38: r = 64'h81c2c92e47edaee6; 7'd39: r = 64'h92722c851482353b;
      7'd40: r = 64'ha2bfe8a14cf10364; 7'd41: r = 64'ha81a664bbc423001;
      7'd42: r = 64'hc24b8b70d0f89791; 7'd43: r = 64'hc76c51a30654be30;
      7'd44: r = 64'hd192e819d6ef5218; 7'd45: r = 64'hd69906245565a910;
      7'd46: r = 64'hf40e35855771202a; 7'd47: r = 64'h106aa07032bbd1b8;
      7'd48: r = 64'h19a4c116b8d2d0c8; 7'd49: r = 64'h1e376c085141ab53;
      7'd50: r = 64'h2748774cdf8eeb99; 7'd51: r = 64'h34b0bcb5e19b48a8;
      7'd52: r = 64'h391c0cb3c5c95a63; 7'd53: r = 64'h4ed8aa4ae3418acb;
      7'd54: r = 64'h5b9cca4f7763e373; 7'd55: r = 64'h682e6ff3d6b2b8a3;
      7'd56: r = 64'h748f82ee5defb2fc; 7'd57: r = 64'h78a5636f43172f60;
      7'd58: r = 64'h84c87814a1f0ab72; 7'd59: r = 64'h8cc702081a6439ec;
      7'd60: r = 64'h90befffa23631e28; 7'd61: r = 64'ha4506cebde82bde9;
      7'd62: r = 64'hbef9a3f7b2c67915; 7'd63: r = 64'hc67178f2e372532b;
      7'd64: r = 64'hca273eceea26619c; 7'd65: r = 64'hd186b8c721c0c207;
      7'd66: r = 64'heada7dd6cde0eb1e; 7'd67: r = 64'hf57d4f7fee6ed178;
      7'd68: r = 64'h06f067aa72176fba; 7'd69: r = 64'h0a637dc5a2c898a6;
      7'd70: r = 64'h113f9804bef90dae; 7'd71: r = 64'h1b710b35131c471b;
      7'd72: r = 64'h28db77f523047d84; 7'd73: r = 64'h32caab7b40c72493;
      7'd74: r = 64'h3c9ebe0a15c9bebc; 7'd75: r = 64'h431d67c49c100d4c;
      7'd76: r = 64'h4cc5d4becb3e42b6; 7'd77: r = 64'h597f299cfc657e2a;
      7'd78: r = 64'h5fcb6fab3ad6faec; 7'd79: r = 64'h6c44198c4a475817;
      default: r = '0;
    endcase
    return r;
  endfunction

  function automatic logic [63:0] rotr(input logic [63:0] x, input int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic logic [63:0] big_sigma0(input logic [63:0] x);
    return rotr(x, 28) ^ rotr(x, 34) ^ rotr(x, 39);
  endfunction

  function automatic logic [63:0] big_sigma1(input logic [63:0] x);
    return rotr(x, 14) ^ rotr(x, 18) ^ rotr(x, 41);
  endfunction

  function automatic logic [63:0] small_sigma0(input logic [63:0] x);
    return rotr(x, 1) ^ rotr(x, 8) ^ (x >> 7);
  endfunction

  function automatic logic [63:0] small_sigma1(input logic [63:0] x);
    return rotr(x, 19) ^ rotr(x, 61) ^ (x >> 6);
  endfunction

endpackage
`default_nettype wire

### hw/rtl/sha512_if.sv
// Interfaces: message word channel and digest word channel.
`timescale 1ns / 1ps
`default_nettype none
interface sha512_in_if;
  logic        valid;
  logic        ready;
  logic [63:0] data_word;
  logic [3:0]  byte_count;
  logic        final_word;
  modport source (output valid, data_word, byte_count, final_word, input ready);
  modport sink (input valid, data_word, byte_count, final_word, output ready);
endinterface

interface sha512_out_if;
  logic        valid;
  logic        ready;
  logic [63:0] digest_word;
  logic        digest_last;
  modport source (output valid, digest_word, digest_last, input ready);
  modport sink (input valid, digest_word, digest_last, output ready);
endinterface
`default_nettype wire

### hw/rtl/sha512_front.sv
// Front end: accepts message words and expands the final word into padding.
`timescale 1ns / 1ps
`default_nettype none
module sha512_front (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  sha512_in_if.sink                 in_ch,
  output sha512_pkg::push_req_t     push_req,
  input  wire logic                 push_ready
);

  sha512_pkg::front_state_t state_r, state_nxt;
  logic [3:0]  pos_r, pos_nxt;
  logic [63:0] bits_r, bits_nxt;

  logic [3:0]  cnt;
  logic [6:0]  cnt_bits;
  logic [63:0] keep, marker;
  logic        in_fire, push_fire;

  // Clamp the byte count to a full word.
  assign cnt      = (in_ch.byte_count > 4'd8) ? 4'd8 : in_ch.byte_count;
  assign cnt_bits = {cnt, 3'b000};
  assign keep     = (cnt == 4'd0) ? 64'd0 : (~64'd0 << (7'd64 - cnt_bits));
  assign marker   = 64'h80 << (7'd56 - cnt_bits);

  assign in_fire   = in_ch.valid && in_ch.ready;
  assign push_fire = push_req.valid && push_ready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha512_pkg::FS_ACCEPT: begin
        if (in_fire && in_ch.final_word) begin
          state_nxt = (cnt == 4'd8) ? sha512_pkg::FS_MARK : sha512_pkg::FS_PAD;
        end
      end
      sha512_pkg::FS_MARK: begin
        if (push_ready) state_nxt = sha512_pkg::FS_PAD;
      end
      sha512_pkg::FS_PAD: begin
        if (push_ready && pos_r == 4'd14) state_nxt = sha512_pkg::FS_LEN;
      end
      sha512_pkg::FS_LEN: begin
        if (push_ready) state_nxt = sha512_pkg::FS_ACCEPT;
      end
      default: state_nxt = sha512_pkg::FS_ACCEPT;
    endcase
  end

  always_comb begin
    in_ch.ready        = 1'b0;
    push_req.valid     = 1'b0;
    push_req.data.word = '0;
    push_req.data.last = 1'b0;
    case (state_r)
      sha512_pkg::FS_ACCEPT: begin
        in_ch.ready    = push_ready;
        push_req.valid = in_ch.valid;
        if (in_ch.final_word && cnt != 4'd8) begin
          push_req.data.word = (in_ch.data_word & keep) | marker;
        end else begin
          push_req.data.word = in_ch.data_word;
        end
      end
      sha512_pkg::FS_MARK: begin
        push_req.valid     = 1'b1;
        push_req.data.word = 64'h8000000000000000;
      end
      sha512_pkg::FS_PAD: begin
        push_req.valid = 1'b1;
      end
      sha512_pkg::FS_LEN: begin
        push_req.valid     = 1'b1;
        push_req.data.word = bits_r;
        push_req.data.last = 1'b1;
      end
      default: ;
    endcase
  end

  always_comb begin
    pos_nxt  = push_fire ? pos_r + 4'd1 : pos_r;
    bits_nxt = bits_r;
    if (in_fire) begin
      bits_nxt = bits_r + (in_ch.final_word ? {57'd0, cnt_bits} : 64'd64);
    end
    if (push_fire && state_r == sha512_pkg::FS_LEN) bits_nxt = '0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha512_pkg::FS_ACCEPT;
      pos_r   <= '0;
      bits_r  <= '0;
    end else begin
      state_r <= state_nxt;
      pos_r   <= pos_nxt;
      bits_r  <= bits_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sha512_queue.sv
// Short FIFO of padded words between the front end and the compression core.
`timescale 1ns / 1ps
`default_nettype none
module sha512_queue (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire sha512_pkg::push_req_t  wr_req,
  output logic                        wr_ready,
  output sha512_pkg::push_req_t       rd_req,
  input  wire logic                   rd_ready
);

  localparam int unsigned CNT_W = sha512_pkg::QPTR_W + 1;

  sha512_pkg::push_t mem_r [sha512_pkg::QUEUE_DEPTH];
  logic [sha512_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0]              fill_r;
  logic                          wr_fire, rd_fire;

  assign wr_ready    = fill_r != CNT_W'(sha512_pkg::QUEUE_DEPTH);
  assign rd_req.valid = fill_r != '0;
  assign rd_req.data  = mem_r[rd_ptr_r];
  assign wr_fire     = wr_req.valid && wr_ready;
  assign rd_fire     = rd_req.valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_fire) mem_r[wr_ptr_r] <= wr_req.data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      fill_r   <= '0;
    end else begin
      if (wr_fire) wr_ptr_r <= wr_ptr_r + 1'b1;
      if (rd_fire) rd_ptr_r <= rd_ptr_r + 1'b1;
      if (wr_fire && !rd_fire) fill_r <= fill_r + 1'b1;
      else if (rd_fire && !wr_fire) fill_r <= fill_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/sha512_core.sv
// Compression core: block buffer, 80 rounds, chaining value and digest output.
`timescale 1ns / 1ps
`default_nettype none
module sha512_core (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire sha512_pkg::push_req_t  pop_req,
  output logic                        pop_ready,
  sha512_out_if.source                out_ch
);

  sha512_pkg::back_state_t state_r, state_nxt;
  logic [63:0] sched_r [sha512_pkg::BLOCK_WORDS];
  logic [63:0] v_r [8];
  logic [63:0] h_r [8];
  logic [6:0]  cnt_r;
  logic        last_r;
  logic [2:0]  idx_r;

  logic        pop_fire, out_fire;
  logic [63:0] w_new, t1, t2;

  assign pop_fire = pop_req.valid && pop_ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  assign w_new = sha512_pkg::small_sigma1(sched_r[14]) + sched_r[9]
               + sha512_pkg::small_sigma0(sched_r[1]) + sched_r[0];
  assign t1 = v_r[7] + sha512_pkg::big_sigma1(v_r[4])
            + ((v_r[4] & v_r[5]) ^ (~v_r[4] & v_r[6]))
            + sha512_pkg::round_const(cnt_r) + sched_r[0];
  assign t2 = sha512_pkg::big_sigma0(v_r[0])
            + ((v_r[0] & v_r[1]) ^ (v_r[0] & v_r[2]) ^ (v_r[1] & v_r[2]));

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      sha512_pkg::BS_LOAD: begin
        if (pop_fire && cnt_r == 7'd15) state_nxt = sha512_pkg::BS_ROUND;
      end
      sha512_pkg::BS_ROUND: begin
        if (cnt_r == 7'(sha512_pkg::ROUNDS - 1)) state_nxt = sha512_pkg::BS_UPDATE;
      end
      sha512_pkg::BS_UPDATE: begin
        state_nxt = last_r ? sha512_pkg::BS_EMIT : sha512_pkg::BS_LOAD;
      end
      sha512_pkg::BS_EMIT: begin
        if (out_fire && idx_r == 3'd7) state_nxt = sha512_pkg::BS_LOAD;
      end
      default: state_nxt = sha512_pkg::BS_LOAD;
    endcase
  end

  always_comb begin
    pop_ready          = state_r == sha512_pkg::BS_LOAD;
    out_ch.valid       = state_r == sha512_pkg::BS_EMIT;
    out_ch.digest_word = h_r[idx_r];
    out_ch.digest_last = idx_r == 3'd7;
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state_r)
      sha512_pkg::BS_LOAD: begin
        if (pop_fire) begin
          for (int i = 0; i < 15; i++) sched_r[i] <= sched_r[i+1];
          sched_r[15] <= pop_req.data.word;
          last_r      <= pop_req.data.last;
          if (cnt_r == 7'd15) begin
            for (int i = 0; i < 8; i++) v_r[i] <= h_r[i];
          end
        end
      end
      sha512_pkg::BS_ROUND: begin
        for (int i = 0; i < 15; i++) sched_r[i] <= sched_r[i+1];
        sched_r[15] <= w_new;
        v_r[7] <= v_r[6];
        v_r[6] <= v_r[5];
        v_r[5] <= v_r[4];
        v_r[4] <= v_r[3] + t1;
        v_r[3] <= v_r[2];
        v_r[2] <= v_r[1];
        v_r[1] <= v_r[0];
        v_r[0] <= t1 + t2;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= sha512_pkg::BS_LOAD;
      cnt_r   <= '0;
      idx_r   <= '0;
      for (int i = 0; i < 8; i++) h_r[i] <= sha512_pkg::init_value(3'(i));
    end else begin
      state_r <= state_nxt;
      case (state_r)
        sha512_pkg::BS_LOAD: begin
          if (pop_fire) cnt_r <= (cnt_r == 7'd15) ? 7'd0 : cnt_r + 7'd1;
        end
        sha512_pkg::BS_ROUND: begin
          cnt_r <= (cnt_r == 7'(sha512_pkg::ROUNDS - 1)) ? 7'd0 : cnt_r + 7'd1;
        end
        sha512_pkg::BS_UPDATE: begin
          for (int i = 0; i < 8; i++) h_r[i] <= h_r[i] + v_r[i];
        end
        sha512_pkg::BS_EMIT: begin
          if (out_fire) begin
            idx_r <= idx_r + 3'd1;
            if (idx_r == 3'd7) begin
              for (int i = 0; i < 8; i++) h_r[i] <= sha512_pkg::init_value(3'(i));
            end
          end
        end
        default: ;
      endcase
    end
  end

  a_round_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha512_pkg::BS_ROUND |-> cnt_r < 7'(sha512_pkg::ROUNDS))
    else $error("round index out of range");

  a_update_after_rounds: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == sha512_pkg::BS_UPDATE |-> $past(state_r) == sha512_pkg::BS_ROUND)
    else $error("chaining update without rounds");

  a_iv_after_digest: assert property (@(posedge clk) disable iff (!rst_n)
    out_fire && out_ch.digest_last |=> state_r == sha512_pkg::BS_LOAD
      && h_r[0] == sha512_pkg::init_value(3'd0) && cnt_r == 7'd0)
    else $error("chaining value not restored after digest");

endmodule
`default_nettype wire

### hw/rtl/sha512_hash_engine_top.sv
// Top level of the SHA-512 hash engine.
// The engine hashes a message given as big-endian 64-bit words on in_ch; each
// word carries a valid-byte count (read only on the final word) and a final
// flag. Eight digest words leave on out_ch, H0 first, with digest_last on the
// eighth. A front end takes one word per cycle while the queue has room and
// it is not padding, applies 0x80 padding, zero fill and the 128-bit length,
// and feeds a four-entry queue; the core drains it into a 16-word shift
// buffer and runs one compression round per cycle. A 1024-bit block is
// loaded as 16 words, then takes 80 rounds and one chaining update, bounded
// by the single round unit. A final word completes its block and adds at most
// one extra padding block, then the eight digest words. The front keeps
// filling the queue while the core computes or waits on the output.
`timescale 1ns / 1ps
`default_nettype none
module sha512_hash_engine_top (
  input  wire logic      clk,
  input  wire logic      rst_n,
  sha512_in_if.sink      in_ch,
  sha512_out_if.source   out_ch
);

  sha512_pkg::push_req_t front_req, queue_req;
  logic                  front_ready, core_ready;

  // Classify and pad incoming transactions.
  sha512_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_ch      (in_ch),
    .push_req   (front_req),
    .push_ready (front_ready)
  );

  // Decouple the front end from the compression core.
  sha512_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_req   (front_req),
    .wr_ready (front_ready),
    .rd_req   (queue_req),
    .rd_ready (core_ready)
  );

  // Compress blocks and emit the digest.
  sha512_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_req   (queue_req),
    .pop_ready (core_ready),
    .out_ch    (out_ch)
  );

endmodule
`default_nettype wire

### verif/sha512_tb_pkg.sv
// Package: digest predictor and scoreboard class for the SHA-512 engine bench.
`timescale 1ns / 1ps
package sha512_tb_pkg;

  typedef bit [63:0] word64_t;

  function automatic word64_t ror64(word64_t x, int unsigned n);
    return (x >> n) | (x << (64 - n));
  endfunction

  function automatic word64_t iv_word(int unsigned i);
    word64_t iv[8];
    iv = '{64'h6a09e667f3bcc908, 64'hbb67ae8584caa73b, 64'h3c6ef372fe94f82b,
           64'ha54ff53a5f1d36f1, 64'h510e527fade682d1, 64'h9b05688c2b3e6c1f,
           64'h1f83d9abfb41bd6b, 64'h5be0cd19137e2179};
    return iv[i];
  endfunction

  function automatic word64_t kconst(int unsigned t);
    word64_t k[80];
    k = '{
      64'h428a2f98d728ae22, 64'h7137449123ef65cd, 64'hb5c0fbcfec4d3b2f, 64'he9b5dba58189dbbc,
      64'h3956c25bf348b538, 64'h59f111f1b605d019, 64'h923f82a4af194f9b, 64'hab1c5ed5da6d8118,
      64'hd807aa98a3030242, 64'h12835b0145706fbe, 64'h243185be4ee4b28c, 64'h550c7dc3d5ffb4e2,
      64'h72be5d74f27b896f, 64'h80deb1fe3b1696b1, 64'h9bdc06a725c71235, 64'hc19bf174cf692694,
      64'he49b69c19ef14ad2, 64'hefbe4786384f25e3, 64'h0fc19dc68b8cd5b5, 64'h240ca1cc77ac9c65,
      64'h2de92c6f592b0275, 64'h4a7484aa6ea6e483, 64'h5cb0a9dcbd41fbd4, 64'h76f988da831153b5,
      64'h983e5152ee66dfab, 64'ha831c66d2db43210, 64'hb00327c898fb213f, 64'hbf597fc7beef0ee4,
      64'hc6e00bf33da88fc2, 64'hd5a79147930aa725, 64'h06ca6351e003826f, 64'h142929670a0e6e70,
      64'h27b70a8546d22ffc, 64'h2e1b21385c26c926, 64'h4d2c6dfc5ac42aed, 64'h53380d139d95b3df,
      64'h650a73548baf63de, 64'h766a0abb3c77b2a8, 64'h81c2c92e47edaee6, 64'h92722c851482353b,
      64'ha2bfe8a14cf10364, 64'ha81a664bbc423001, 64'hc24b8b70d0f89791, 64'hc76c51a30654be30,
      64'hd192e819d6ef5218, 64'hd69906245565a910, 64'hf40e35855771202a, 64'h106aa07032bbd1b8,
      64'h19a4c116b8d2d0c8, 64'h1e376c085141ab53, 64'h2748774cdf8eeb99, 64'h34b0bcb5e19b48a8,
      64'h391c0cb3c5c95a63, 64'h4ed8aa4ae3418acb, 64'h5b9cca4f7763e373, 64'h682e6ff3d6b2b8a3,
      64'h748f82ee5defb2fc, 64'h78a5636f43172f60, 64'h84c87814a1f0ab72, 64'h8cc702081a6439ec,
      64'h90befffa23631e28, 64'ha4506cebde82bde9, 64'hbef9a3f7b2c67915, 64'hc67178f2e372532b,
      64'hca273eceea26619c, 64'hd186b8c721c0c207, 64'heada7dd6cde0eb1e, 64'hf57d4f7fee6ed178,
      64'h06f067aa72176fba, 64'h0a637dc5a2c898a6, 64'h113f9804bef90dae, 64'h1b710b35131c471b,
      64'h28db77f523047d84, 64'h32caab7b40c72493, 64'h3c9ebe0a15c9bebc, 64'h431d67c49c100d4c,
      64'h4cc5d4becb3e42b6, 64'h597f299cfc657e2a, 64'h5fcb6fab3ad6faec, 64'h6c44198c4a475817};
    return k[t];
  endfunction

  typedef struct {
    word64_t digest_word;
    bit      digest_last;
  } digest_item_t;

  class digest_scoreboard;
    word64_t      hash_state[8];
    word64_t      blk[16];
    int unsigned  fill;
    word64_t      bit_len;
    digest_item_t pending_digest[$];
    int           errors;
    int           digests_seen;
    int           messages;

    function new();
      restart();
      errors = 0;
      digests_seen = 0;
      messages = 0;
    endfunction

    function void restart();
      for (int i = 0; i < 8; i++) hash_state[i] = iv_word(i);
      fill = 0;
      bit_len = '0;
    endfunction

    function void compress_block();
      word64_t v[8];
      word64_t w, t1, t2, p, q;
      for (int i = 0; i < 8; i++) v[i] = hash_state[i];
      for (int t = 0; t < 80; t++) begin
        if (t >= 16) begin
          p = blk[(t - 2) & 15];
          q = blk[(t - 15) & 15];
          w = (ror64(p, 19) ^ ror64(p, 61) ^ (p >> 6)) + blk[(t - 7) & 15]
            + (ror64(q, 1) ^ ror64(q, 8) ^ (q >> 7)) + blk[t & 15];
          blk[t & 15] = w;
        end else begin
          w = blk[t];
        end
        t1 = v[7] + (ror64(v[4], 14) ^ ror64(v[4], 18) ^ ror64(v[4], 41))
           + ((v[4] & v[5]) ^ (~v[4] & v[6])) + kconst(t) + w;
        t2 = (ror64(v[0], 28) ^ ror64(v[0], 34) ^ ror64(v[0], 39))
           + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
        for (int i = 7; i > 0; i--) v[i] = v[i - 1];
        v[4] = v[4] + t1;
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) hash_state[i] += v[i];
    endfunction

    function void append_word(word64_t w);
      blk[fill] = w;
      fill = (fill + 1) & 15;
      if (fill == 0) compress_block();
    endfunction

    // Note an accepted message word; on the final word queue the eight digest words.
    function void note_word(word64_t data, bit [3:0] count, bit fin);
      int unsigned n;
      word64_t keep;
      if (!fin) begin
        bit_len += 64;
        append_word(data);
        return;
      end
      n = (count > 8) ? 8 : count;
      bit_len += n * 8;
      if (n == 8) begin
        append_word(data);
        append_word(64'h8000000000000000);
      end else begin
        keep = (n == 0) ? '0 : ~64'd0 << (64 - 8 * n);
        append_word((data & keep) | (64'h80 << (56 - 8 * n)));
      end
      if (fill > 14) while (fill != 0) append_word('0);
      while (fill < 14) append_word('0);
      append_word('0);
      append_word(bit_len);
      for (int i = 0; i < 8; i++) pending_digest.push_back('{hash_state[i], i == 7});
      messages++;
      restart();
    endfunction

    function void check_digest(word64_t dw, bit dl);
      digest_item_t e;
      digests_seen++;
      if (pending_digest.size() == 0) begin
        $display("%0t: unexpected digest word %h last %0b", $time, dw, dl);
        errors++;
        return;
      end
      e = pending_digest.pop_front();
      if (e.digest_word !== dw) begin
        $display("%0t: digest_word expected %h actual %h", $time, e.digest_word, dw);
        errors++;
      end
      if (e.digest_last !== dl) begin
        $display("%0t: digest_last expected %0b actual %0b", $time, e.digest_last, dl);
        errors++;
      end
    endfunction
  endclass

endpackage

### verif/testbench.sv
// Testbench top: drives message words into the SHA-512 engine and checks digests.
`timescale 1ns / 1ps
module testbench;
  import sha512_tb_pkg::*;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  sha512_in_if  in_ch();
  sha512_out_if out_ch();

  sha512_hash_engine_top i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch.sink),
    .out_ch (out_ch.source)
  );

  digest_scoreboard sb = new();

  // Idle control: idling off during a calm stretch; long receiver hold on request.
  bit calm = 1'b0;
  int hold_cycles = 0;
  int words_sent = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data_word = '0;
    in_ch.byte_count = '0;
    in_ch.final_word = 1'b0;
    out_ch.ready = 1'b0;
  end

  // Send one transaction: hold valid until accepted, with random idle gaps before it.
  task automatic send_word(bit [63:0] d, bit [3:0] c, bit f);
    while (!calm && $urandom_range(99) < 17) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data_word <= d;
    in_ch.byte_count <= c;
    in_ch.final_word <= f;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    sb.note_word(d, c, f);
    words_sent++;
    @(negedge clk);
  endtask

  // Drop valid between messages so the next one starts from a clean edge.
  task automatic go_idle();
    in_ch.valid <= 1'b0;
    @(negedge clk);
  endtask

  function automatic bit [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  // Send a message of nfull full words and a final word with count c.
  task automatic send_message(int nfull, bit [3:0] c);
    for (int i = 0; i < nfull; i++) send_word(rand64(), $urandom_range(15), 1'b0);
    send_word(rand64(), c, 1'b1);
  endtask

  // Receiver: random backpressure, plus an explicit hold counted in cycles here.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else if (hold_cycles > 0) begin
      out_ch.ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ch.ready <= calm ? 1'b1 : ($urandom_range(99) >= 17);
    end
  end

  // Monitor: check every digest transaction at the rising edge.
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) sb.check_digest(out_ch.digest_word, out_ch.digest_last);
  end

  task automatic wait_drained();
    while (sb.pending_digest.size() != 0) @(negedge clk);
  endtask

  initial begin
    int cnt;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: empty message, every byte count, counts above eight, padding boundaries.
    send_word(64'h0, 4'd0, 1'b1);
    send_word(64'hffffffffffffffff, 4'd0, 1'b1);
    for (int c = 1; c <= 8; c++) send_word(64'hffffffffffffffff, c[3:0], 1'b1);
    send_word(64'hffffffffffffffff, 4'd15, 1'b1);
    send_word(64'h0, 4'd9, 1'b1);
    // Short count on a non-final word is ignored; final word lands in buffer positions 13, 14 and 15.
    send_message(13, 4'd3);
    send_message(14, 4'd8);
    send_message(15, 4'd0);
    go_idle();
    wait_drained();

    // Pressure: hold the receiver off while the sender keeps pushing messages.
    hold_cycles = 1500;
    send_message(2, 4'd5);
    send_message(0, 4'd8);
    send_message(3, 4'd1);
    send_message(1, 4'd7);
    go_idle();
    // Pause the sender until every digest has come out.
    wait_drained();

    // Random messages; a calm stretch in the middle.
    while (words_sent < 230) begin
      calm = (words_sent > 120 && words_sent < 170);
      cnt = ($urandom_range(9) == 0) ? $urandom_range(40) : $urandom_range(5);
      send_message(cnt, $urandom_range(15));
      if ($urandom_range(3) == 0) go_idle();
    end
    calm = 1'b0;
    go_idle();
    wait_drained();
    repeat (300) @(negedge clk);

    $display("covered %0d words in %0d messages, %0d digest words checked",
             words_sent, sb.messages, sb.digests_seen);
    $display("byte counts 0..15, block boundary padding, receiver hold and calm stretch");
    if (sb.errors == 0 && sb.pending_digest.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

endmodule

### sha512_hash_engine_top.f
hw/rtl/sha512_pkg.sv
hw/rtl/sha512_if.sv
hw/rtl/sha512_front.sv
hw/rtl/sha512_queue.sv
hw/rtl/sha512_core.sv
hw/rtl/sha512_hash_engine_top.sv
verif/sha512_tb_pkg.sv
verif/testbench.sv
